### rtl/core/tnrc_pkg.sv
package tnrc_pkg;

  // Default number of fraction bits of temperatures, power and conductances.
  localparam int unsigned FRACTION_BITS = 16;
  // Fixed fraction bits of the inverse capacitances and of the time step.
  localparam int unsigned INV_CAP_BITS  = 20;
  localparam int unsigned STEP_BITS     = 32;

  localparam int unsigned WORD_W = 32;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_AMBIENT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_G_JC     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_G_CS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CJ   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CC   = 3'd4;

  // Register values after reset.
  localparam logic signed [WORD_W-1:0] AMBIENT_RST = 32'sd1638400;
  localparam logic [WORD_W-1:0]        G_RST       = 32'd65536;
  localparam logic [WORD_W-1:0]        INV_C_RST   = 32'd1048576;

  // Multiply rounds of one Euler step, in the order the sequencer runs them.
  localparam int unsigned ROUNDS = 6;
  localparam int unsigned RND_W  = $clog2(ROUNDS);
  localparam logic [RND_W-1:0] RND_FJC = 3'd0;  // junction-to-case heat flow
  localparam logic [RND_W-1:0] RND_FCS = 3'd1;  // case-to-sink heat flow
  localparam logic [RND_W-1:0] RND_RJ  = 3'd2;  // junction temperature rate
  localparam logic [RND_W-1:0] RND_RC  = 3'd3;  // case temperature rate
  localparam logic [RND_W-1:0] RND_DJ  = 3'd4;  // junction increment
  localparam logic [RND_W-1:0] RND_DC  = 3'd5;  // case increment

  typedef enum logic [1:0] {
    SCALE_FRAC,
    SCALE_INVCAP,
    SCALE_STEP
  } scale_e;

  typedef struct packed {
    logic signed [WORD_W-1:0] power_loss;
    logic [WORD_W-1:0]        time_step;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] junction_temperature;
    logic signed [WORD_W-1:0] case_temperature;
  } out_item_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic [RND_W-1:0] round;
    logic             alu_en;
    logic             mul_en;
    logic             shf_en;
    logic             add_j;
    logic             add_c;
    logic             finish;
  } ctl_t;

  // Saturates a sign-extended wide value to the signed 32-bit range.
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [63:0] v);
    logic signed [WORD_W-1:0] r;
    if (v[63:31] == '0 || v[63:31] == '1) begin
      r = v[31:0];
    end else if (v[63]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

### rtl/core/two_node_thermal_rc_step.sv
// Channel   Direction  Handshake                   Payload
// input     in         in_valid_i / in_ready_o     in_data_i  (power_loss, time_step)
// output    out        out_valid_o / out_ready_i   out_data_o (junction, case temperature)
// config    in         cfg_we_i (no wait)          cfg_index_i, cfg_data_i
//
// An item's result reaches the output register in its clamp state, and the input
// accepts no new item until the sequencer has returned to idle. The time taken is
// set by the single shared multiplier: six multiplies, each with an operand step,
// a product step and a scaling step, followed by two additions and the clamp.
// Reset is asynchronous and active low; it loads the register defaults and sets
// both nodes to the default ambient. A result waiting on out_ready_i does not
// block the next item, which only stalls at its clamp cycle until the slot frees.
module two_node_thermal_rc_step #(
  parameter int unsigned FracBits = tnrc_pkg::FRACTION_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  tnrc_pkg::in_item_t       in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output tnrc_pkg::out_item_t      out_data_o,
  input  logic                     cfg_we_i,
  input  logic [tnrc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]              cfg_data_i
);
  import tnrc_pkg::*;

  // Configuration registers.
  logic signed [31:0] amb_q;
  logic [31:0]        gjc_q;
  logic [31:0]        gcs_q;
  logic [31:0]        icj_q;
  logic [31:0]        icc_q;

  // Node state: the temperatures held between items.
  logic signed [31:0] tj_q;
  logic signed [31:0] tc_q;

  // Item operands and intermediate results.
  logic signed [31:0] pwr_q;
  logic [31:0]        dt_q;
  logic signed [31:0] opa_q;
  logic signed [31:0] res_q [ROUNDS];
  logic signed [31:0] nj_q;
  logic signed [31:0] nc_q;

  out_item_t          out_q;
  logic               out_valid_q;

  ctl_t               ctl;
  logic               seq_idle;
  logic               in_fire;
  logic               out_free;

  logic signed [31:0] alu_x;
  logic signed [31:0] alu_y;
  logic               alu_sub;
  logic signed [32:0] alu_wide;
  logic signed [31:0] alu_res;

  logic [31:0]        mul_b;
  scale_e             mul_scale;
  logic signed [31:0] mul_res;

  logic signed [31:0] clamp_j;
  logic signed [31:0] clamp_c_hi;
  logic signed [31:0] clamp_c;

  assign in_ready_o = seq_idle;
  assign in_fire    = in_valid_i && seq_idle;
  assign out_free   = !out_valid_q || out_ready_i;

  tnrc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .out_free_i (out_free),
    .idle_o     (seq_idle),
    .ctl_o      (ctl)
  );

  // The adder forms every difference of a round, and the two final sums.
  // The increment rounds pass their rate through unchanged by subtracting zero.
  always_comb begin
    alu_sub = 1'b1;
    alu_x   = '0;
    alu_y   = '0;
    if (ctl.add_j) begin
      alu_sub = 1'b0;
      alu_x   = tj_q;
      alu_y   = res_q[RND_DJ];
    end else if (ctl.add_c) begin
      alu_sub = 1'b0;
      alu_x   = tc_q;
      alu_y   = res_q[RND_DC];
    end else begin
      case (ctl.round)
        RND_FJC: begin
          alu_x = tj_q;
          alu_y = tc_q;
        end
        RND_FCS: begin
          alu_x = tc_q;
          alu_y = amb_q;
        end
        RND_RJ: begin
          alu_x = pwr_q;
          alu_y = res_q[RND_FJC];
        end
        RND_RC: begin
          alu_x = res_q[RND_FJC];
          alu_y = res_q[RND_FCS];
        end
        RND_DJ: alu_x = res_q[RND_RJ];
        RND_DC: alu_x = res_q[RND_RC];
        default: alu_x = '0;
      endcase
    end
  end

  assign alu_wide = alu_sub ? ({alu_x[31], alu_x} - {alu_y[31], alu_y})
                            : ({alu_x[31], alu_x} + {alu_y[31], alu_y});
  assign alu_res  = sat_word({{31{alu_wide[32]}}, alu_wide});

  // The multiplier's second operand and scaling follow the round.
  always_comb begin
    case (ctl.round)
      RND_FJC: begin
        mul_b     = gjc_q;
        mul_scale = SCALE_FRAC;
      end
      RND_FCS: begin
        mul_b     = gcs_q;
        mul_scale = SCALE_FRAC;
      end
      RND_RJ: begin
        mul_b     = icj_q;
        mul_scale = SCALE_INVCAP;
      end
      RND_RC: begin
        mul_b     = icc_q;
        mul_scale = SCALE_INVCAP;
      end
      default: begin
        mul_b     = dt_q;
        mul_scale = SCALE_STEP;
      end
    endcase
  end

  tnrc_mul #(
    .FracBits (FracBits)
  ) u_mul (
    .clk_i   (clk_i),
    .load_i  (ctl.mul_en),
    .a_i     (opa_q),
    .b_i     (mul_b),
    .scale_i (mul_scale),
    .res_o   (mul_res)
  );

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pwr_q <= in_data_i.power_loss;
      dt_q  <= in_data_i.time_step;
    end
    if (ctl.alu_en) begin
      opa_q <= alu_res;
    end
    if (ctl.shf_en) begin
      res_q[ctl.round] <= mul_res;
    end
    if (ctl.add_j) begin
      nj_q <= alu_res;
    end
    if (ctl.add_c) begin
      nc_q <= alu_res;
    end
  end

  // Junction never falls below ambient; the case lies between ambient and the
  // new junction temperature.
  always_comb begin
    clamp_j    = (nj_q < amb_q) ? amb_q : nj_q;
    clamp_c_hi = (nc_q > clamp_j) ? clamp_j : nc_q;
    clamp_c    = (clamp_c_hi < amb_q) ? amb_q : clamp_c_hi;
  end

  // A write of ambient reloads both nodes and takes precedence over an update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amb_q <= AMBIENT_RST;
      gjc_q <= G_RST;
      gcs_q <= G_RST;
      icj_q <= INV_C_RST;
      icc_q <= INV_C_RST;
      tj_q  <= AMBIENT_RST;
      tc_q  <= AMBIENT_RST;
    end else begin
      if (ctl.finish) begin
        tj_q <= clamp_j;
        tc_q <= clamp_c;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_AMBIENT: begin
            amb_q <= cfg_data_i;
            tj_q  <= cfg_data_i;
            tc_q  <= cfg_data_i;
          end
          REG_G_JC:   gjc_q <= cfg_data_i;
          REG_G_CS:   gcs_q <= cfg_data_i;
          REG_INV_CJ: icj_q <= cfg_data_i;
          REG_INV_CC: icc_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Output register: holds one finished item while the next one is computed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.finish) begin
      out_q.junction_temperature <= clamp_j;
      out_q.case_temperature     <= clamp_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_junction_above_ambient: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tj_q >= amb_q)
    else $error("junction node fell below ambient");
  a_case_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tc_q >= amb_q && tc_q <= tj_q)
    else $error("case node outside ambient to junction range");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an item was accepted");
`endif

endmodule

### rtl/core/tnrc_mul.sv
module tnrc_mul #(
  parameter int unsigned FracBits = tnrc_pkg::FRACTION_BITS
) (
  input  logic                   clk_i,
  input  logic                   load_i,
  input  logic signed [31:0]     a_i,
  input  logic [31:0]            b_i,
  input  tnrc_pkg::scale_e       scale_i,
  output logic signed [31:0]     res_o
);
  import tnrc_pkg::*;

  logic signed [32:0] a_x;
  logic signed [32:0] b_x;
  logic signed [65:0] full;
  logic signed [63:0] prod_q;
  scale_e             scale_q;
  logic signed [63:0] shifted;

  // Signed times unsigned: the product always fits in 64 bits.
  assign a_x  = {a_i[31], a_i};
  assign b_x  = {1'b0, b_i};
  assign full = a_x * b_x;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q  <= full[63:0];
      scale_q <= scale_i;
    end
  end

  // Arithmetic shift rounds toward minus infinity.
  always_comb begin
    unique case (scale_q)
      SCALE_FRAC:   shifted = prod_q >>> FracBits;
      SCALE_INVCAP: shifted = prod_q >>> INV_CAP_BITS;
      SCALE_STEP:   shifted = prod_q >>> STEP_BITS;
      default:      shifted = '0;
    endcase
  end

  assign res_o = sat_word(shifted);

endmodule

### rtl/core/tnrc_seq.sv
module tnrc_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_fire_i,
  input  logic           out_free_i,
  output logic           idle_o,
  output tnrc_pkg::ctl_t ctl_o
);
  import tnrc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUB   = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_SHF   = 3'd3;
  localparam logic [2:0] S_ADDJ  = 3'd4;
  localparam logic [2:0] S_ADDC  = 3'd5;
  localparam logic [2:0] S_CLAMP = 3'd6;

  localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS - 1);

  logic [2:0]       state_q, state_d;
  logic [RND_W-1:0] round_q, round_d;

  always_comb begin
    state_d = state_q;
    round_d = round_q;
    unique case (state_q)
      S_IDLE: begin
        round_d = '0;
        if (in_fire_i) begin
          state_d = S_SUB;
        end
      end
      S_SUB: state_d = S_MUL;
      S_MUL: state_d = S_SHF;
      S_SHF: begin
        if (round_q == RND_LAST) begin
          state_d = S_ADDJ;
        end else begin
          round_d = round_q + 1'b1;
          state_d = S_SUB;
        end
      end
      S_ADDJ: state_d = S_ADDC;
      S_ADDC: state_d = S_CLAMP;
      S_CLAMP: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      round_q <= '0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
    end
  end

  assign idle_o        = (state_q == S_IDLE);
  assign ctl_o.round   = round_q;
  assign ctl_o.alu_en  = (state_q == S_SUB);
  assign ctl_o.mul_en  = (state_q == S_MUL);
  assign ctl_o.shf_en  = (state_q == S_SHF);
  assign ctl_o.add_j   = (state_q == S_ADDJ);
  assign ctl_o.add_c   = (state_q == S_ADDC);
  assign ctl_o.finish  = (state_q == S_CLAMP) && out_free_i;

`ifndef SYNTHESIS
  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> round_q <= RND_LAST)
    else $error("round counter out of range");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i && state_q == S_IDLE |=> state_q == S_SUB && round_q == '0)
    else $error("item start did not begin at the first round");
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.finish |=> state_q == S_IDLE)
    else $error("sequencer did not return to idle after finishing");
`endif

endmodule
